// ===== rtl/core/sliding_mode_position_controller_unit_assert.svh =====
// assertion macros for the sliding mode position controller
`ifndef SLIDING_MODE_POSITION_CONTROLLER_UNIT_ASSERT_SVH
`define SLIDING_MODE_POSITION_CONTROLLER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define SMPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("smpc assertion failed");

`define SMPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("smpc implication failed");

`define SMPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("smpc next-cycle check failed");

`else

`define SMPC_ASSERT(lbl, clk, rstn, prop)
`define SMPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SMPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/smpc_pkg.sv =====
`default_nettype none

package smpc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int REG_W     = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1) << FRAC_BITS;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOPE    = 3'd0,
    CFG_REACH    = 3'd1,
    CFG_SWITCH   = 3'd2,
    CFG_INERTIA  = 3'd3,
    CFG_DEADBAND = 3'd4,
    CFG_LIMIT    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0] slope;
    logic [REG_W-1:0] reach;
    logic [REG_W-1:0] switching;
    logic [REG_W-1:0] inertia;
    logic [REG_W-1:0] deadband;
    logic [REG_W-1:0] limit;
  } cfg_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_e;

  typedef struct packed {
    alu_op_e                  op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } alu_req_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/smpc_cfg.sv =====
`default_nettype none

module smpc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [smpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [smpc_pkg::REG_W-1:0]       cfg_wdata_i,
  output smpc_pkg::cfg_t                   cfg_o
);
  import smpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLOPE:    cfg_d.slope     = cfg_wdata_i;
        CFG_REACH:    cfg_d.reach     = cfg_wdata_i;
        CFG_SWITCH:   cfg_d.switching = cfg_wdata_i;
        CFG_INERTIA:  cfg_d.inertia   = cfg_wdata_i;
        CFG_DEADBAND: cfg_d.deadband  = cfg_wdata_i;
        CFG_LIMIT:    cfg_d.limit     = cfg_wdata_i;
        default:      cfg_d = cfg_q;  // unmapped index, drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope     <= REG_W'(65536);
      cfg_q.reach     <= '0;
      cfg_q.switching <= '0;
      cfg_q.inertia   <= REG_W'(65536);
      cfg_q.deadband  <= '0;
      cfg_q.limit     <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/smpc_alu.sv =====
`default_nettype none

module smpc_alu (
  input  logic                                clk_i,
  input  smpc_pkg::alu_req_t                  req_i,
  output logic signed [smpc_pkg::DATA_W-1:0]  res_o
);
  import smpc_pkg::*;

  logic signed [63:0] raw_d, raw_q;
  logic signed [63:0] scaled;
  logic               mul_q;

  always_comb begin
    case (req_i.op)
      ALU_ADD: raw_d = 64'(req_i.a) + 64'(req_i.b);
      ALU_SUB: raw_d = 64'(req_i.a) - 64'(req_i.b);
      ALU_MUL: raw_d = req_i.a * req_i.b;
      default: raw_d = '0;
    endcase
  end

  // the exact sum or product is registered; scaling and saturation act on the registered value
  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;
    mul_q <= (req_i.op == ALU_MUL);
  end

  // arithmetic shift floors toward minus infinity
  assign scaled = mul_q ? (raw_q >>> FRAC_BITS) : raw_q;
  assign res_o  = sat32(scaled);

endmodule

`default_nettype wire

// ===== rtl/core/sliding_mode_position_controller_unit.sv =====
// Sliding mode position controller with an exponential reaching law, signed Q16.16 throughout.
// One sample (angle, velocity, target) yields one drive value. All sums and products go
// through a single shared add/multiply unit; a sample needs thirteen operations, or three
// when the position error lies inside the deadband. The input is not ready from the
// transfer until the result has been taken. Gains and limits are to be written through
// the register port while the block is idle; the block itself does not enforce this.
// Unmapped indexes are ignored.
`default_nettype none

`include "sliding_mode_position_controller_unit_assert.svh"

module sliding_mode_position_controller_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [smpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [smpc_pkg::REG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [smpc_pkg::DATA_W-1:0]  measured_angle_i,
  input  logic signed [smpc_pkg::DATA_W-1:0]  measured_velocity_i,
  input  logic signed [smpc_pkg::DATA_W-1:0]  target_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [smpc_pkg::DATA_W-1:0]  drive_o,
  output logic                                in_deadband_o
);
  import smpc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WB   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  typedef enum logic [3:0] {
    STEP_ERR    = 4'd0,
    STEP_D      = 4'd1,
    STEP_DD     = 4'd2,
    STEP_VREL   = 4'd3,
    STEP_MUL_CE = 4'd4,
    STEP_S      = 4'd5,
    STEP_MUL_CV = 4'd6,
    STEP_U1     = 4'd7,
    STEP_MUL_EP = 4'd8,
    STEP_U2     = 4'd9,
    STEP_MUL_K  = 4'd10,
    STEP_U3     = 4'd11,
    STEP_MUL_J  = 4'd12
  } step_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;

  cfg_t     cfg;
  alu_req_t alu_req;
  logic signed [DATA_W-1:0] alu_res;

  logic signed [DATA_W-1:0] angle_q, vel_q, tgt_q;
  logic signed [DATA_W-1:0] err_q, d_q, dd_q, vrel_q, s_q, u_q, tmp_q;
  logic signed [DATA_W-1:0] prev_t_q, prev_step_q;
  logic signed [DATA_W-1:0] drive_q;
  logic                     dbz_q;

  logic signed [DATA_W-1:0] sc;
  logic [DATA_W:0]          abs_err;
  logic                     in_db;
  logic signed [DATA_W-1:0] lim_s, neg_lim_s, u_clamped;
  logic                     last_op, db_exit;
  logic                     in_xfer;

  smpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  smpc_alu u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign in_xfer = in_valid_i && in_ready_o;

  // surface saturated to +-1
  always_comb begin
    if (s_q > Q_ONE) begin
      sc = Q_ONE;
    end else if (s_q < -Q_ONE) begin
      sc = -Q_ONE;
    end else begin
      sc = s_q;
    end
  end

  assign abs_err = err_q[DATA_W-1] ? ((DATA_W+1)'(0) - {err_q[DATA_W-1], err_q})
                                   : {1'b0, err_q};
  assign in_db   = abs_err < {2'b00, cfg.deadband};

  assign lim_s     = {1'b0, cfg.limit};
  assign neg_lim_s = -lim_s;

  always_comb begin
    if (alu_res > lim_s) begin
      u_clamped = lim_s;
    end else if (alu_res < neg_lim_s) begin
      u_clamped = neg_lim_s;
    end else begin
      u_clamped = alu_res;
    end
  end

  // operand selection for the shared unit
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = angle_q;
    alu_req.b  = tgt_q;
    case (step_q)
      STEP_ERR:    begin alu_req.op = ALU_SUB; alu_req.a = angle_q; alu_req.b = tgt_q; end
      STEP_D:      begin alu_req.op = ALU_SUB; alu_req.a = tgt_q;   alu_req.b = prev_t_q; end
      STEP_DD:     begin alu_req.op = ALU_SUB; alu_req.a = d_q;     alu_req.b = prev_step_q; end
      STEP_VREL:   begin alu_req.op = ALU_SUB; alu_req.a = vel_q;   alu_req.b = d_q; end
      STEP_MUL_CE: begin alu_req.op = ALU_MUL; alu_req.a = {1'b0, cfg.slope}; alu_req.b = err_q; end
      STEP_S:      begin alu_req.op = ALU_ADD; alu_req.a = tmp_q;   alu_req.b = vrel_q; end
      STEP_MUL_CV: begin alu_req.op = ALU_MUL; alu_req.a = {1'b0, cfg.slope}; alu_req.b = vrel_q; end
      STEP_U1:     begin alu_req.op = ALU_SUB; alu_req.a = dd_q;    alu_req.b = tmp_q; end
      STEP_MUL_EP: begin
        alu_req.op = ALU_MUL; alu_req.a = {1'b0, cfg.switching}; alu_req.b = sc;
      end
      STEP_U2:     begin alu_req.op = ALU_SUB; alu_req.a = u_q;     alu_req.b = tmp_q; end
      STEP_MUL_K:  begin alu_req.op = ALU_MUL; alu_req.a = {1'b0, cfg.reach}; alu_req.b = s_q; end
      STEP_U3:     begin alu_req.op = ALU_SUB; alu_req.a = u_q;     alu_req.b = tmp_q; end
      STEP_MUL_J:  begin alu_req.op = ALU_MUL; alu_req.a = {1'b0, cfg.inertia}; alu_req.b = u_q; end
      default:     begin alu_req.op = ALU_SUB; alu_req.a = angle_q; alu_req.b = tgt_q; end
    endcase
  end

  assign last_op = (state_q == ST_WB) && (step_q == STEP_MUL_J);
  assign db_exit = (state_q == ST_WB) && (step_q == STEP_DD) && in_db;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
          step_d  = STEP_ERR;
        end
      end
      ST_EXEC: state_d = ST_WB;
      ST_WB: begin
        if (last_op || db_exit) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_EXEC;
          step_d  = step_e'(step_q + 4'd1);
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_ERR;
      prev_t_q    <= '0;
      prev_step_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (last_op || db_exit) begin
        prev_step_q <= d_q;
      end
      if (last_op) begin
        prev_t_q <= tgt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      angle_q <= measured_angle_i;
      vel_q   <= measured_velocity_i;
      tgt_q   <= target_angle_i;
    end
    if (state_q == ST_WB) begin
      case (step_q)
        STEP_ERR:    err_q  <= alu_res;
        STEP_D:      d_q    <= alu_res;
        STEP_DD:     dd_q   <= alu_res;
        STEP_VREL:   vrel_q <= alu_res;
        STEP_S:      s_q    <= alu_res;
        STEP_U1:     u_q    <= alu_res;
        STEP_U2:     u_q    <= alu_res;
        STEP_U3:     u_q    <= alu_res;
        STEP_MUL_J:  u_q    <= alu_res;
        default:     tmp_q  <= alu_res;  // products that feed the next step
      endcase
    end
    if (db_exit) begin
      drive_q <= '0;
      dbz_q   <= 1'b1;
    end else if (last_op) begin
      drive_q <= u_clamped;
      dbz_q   <= 1'b0;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign drive_o       = drive_q;
  assign in_deadband_o = dbz_q;

  `SMPC_ASSERT(a_ready_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `SMPC_ASSERT_IMPL(a_db_zero, clk_i, rst_ni, out_valid_o && in_deadband_o, drive_o == '0)
  `SMPC_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

`default_nettype wire

// ===== tb/tb_sliding_mode_position_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_sliding_mode_position_controller_unit;

  import smpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 140;
  localparam int DRAIN_CYCLES   = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic [REG_W-1:0]         REG_MAX  = 31'h7FFF_FFFF;

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic                     in_deadband;
  } drive_result_t;

  class drive_scoreboard;
    logic signed [DATA_W-1:0] slope, reach, switching, inertia, deadband, limit;
    logic signed [DATA_W-1:0] last_target, last_step;
    drive_result_t            expected_drives[$];
    int                       errors;

    function new();
      slope       = 32'sh0001_0000;
      reach       = '0;
      switching   = '0;
      inertia     = 32'sh0001_0000;
      deadband    = '0;
      limit       = WORD_MAX;
      last_target = '0;
      last_step   = '0;
      errors      = 0;
    endfunction

    function logic signed [DATA_W-1:0] clamp32(longint x);
      if (x > longint'(WORD_MAX)) return WORD_MAX;
      if (x < longint'(WORD_MIN)) return WORD_MIN;
      return x[DATA_W-1:0];
    endfunction

    // exact product, arithmetic shift floors toward minus infinity
    function logic signed [DATA_W-1:0] qmul(logic signed [DATA_W-1:0] a,
                                            logic signed [DATA_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp32(p >>> FRAC_BITS);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        CFG_SLOPE:    slope     = {1'b0, val};
        CFG_REACH:    reach     = {1'b0, val};
        CFG_SWITCH:   switching = {1'b0, val};
        CFG_INERTIA:  inertia   = {1'b0, val};
        CFG_DEADBAND: deadband  = {1'b0, val};
        CFG_LIMIT:    limit     = {1'b0, val};
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] angle,
                              logic signed [DATA_W-1:0] vel,
                              logic signed [DATA_W-1:0] target);
      drive_result_t            r;
      logic signed [DATA_W-1:0] err, step, accel, vrel, surf, surf_sat, u, one;
      longint                   mag;
      one   = Q_ONE;
      err   = clamp32(longint'(angle) - longint'(target));
      step  = clamp32(longint'(target) - longint'(last_target));
      accel = clamp32(longint'(step) - longint'(last_step));
      mag   = (err < 0) ? -longint'(err) : longint'(err);
      last_step = step;
      if (mag < longint'(deadband)) begin
        r.drive       = '0;
        r.in_deadband = 1'b1;
      end else begin
        vrel     = clamp32(longint'(vel) - longint'(step));
        surf     = clamp32(longint'(qmul(slope, err)) + longint'(vrel));
        surf_sat = (surf > one) ? one : ((surf < -one) ? -one : surf);
        u = clamp32(longint'(accel) - longint'(qmul(slope, vrel)));
        u = clamp32(longint'(u) - longint'(qmul(switching, surf_sat)));
        u = clamp32(longint'(u) - longint'(qmul(reach, surf)));
        u = qmul(inertia, u);
        if (u > limit) u = limit;
        if (u < -limit) u = -limit;
        last_target   = target;
        r.drive       = u;
        r.in_deadband = 1'b0;
      end
      expected_drives.push_back(r);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] drive, logic in_deadband);
      drive_result_t e;
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual drive %0d in_deadband %0b",
                 $time, drive, in_deadband);
        errors++;
        return;
      end
      e = expected_drives.pop_front();
      if (drive !== e.drive) begin
        $display("%0t: drive mismatch, expected %0d actual %0d", $time, e.drive, drive);
        errors++;
      end
      if (in_deadband !== e.in_deadband) begin
        $display("%0t: in_deadband mismatch, expected %0b actual %0b",
                 $time, e.in_deadband, in_deadband);
        errors++;
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [REG_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] measured_angle_i;
  logic signed [DATA_W-1:0] measured_velocity_i;
  logic signed [DATA_W-1:0] target_angle_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] drive_o;
  logic                     in_deadband_o;

  drive_scoreboard          sb;
  bit                       idle_on;
  bit                       hold_request;
  int                       stall_cycles;
  logic signed [DATA_W-1:0] track_target;
  int unsigned              noise_span;
  int unsigned              step_span;

  sliding_mode_position_controller_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .measured_angle_i    (measured_angle_i),
    .measured_velocity_i (measured_velocity_i),
    .target_angle_i      (target_angle_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .drive_o             (drive_o),
    .in_deadband_o       (in_deadband_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // transfers on both sides feed the scoreboard; the watchdog restarts on any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_sample(measured_angle_i, measured_velocity_i, target_angle_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(drive_o, in_deadband_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  task automatic send_sample(input logic signed [DATA_W-1:0] angle,
                             input logic signed [DATA_W-1:0] vel,
                             input logic signed [DATA_W-1:0] target);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    measured_angle_i    <= angle;
    measured_velocity_i <= vel;
    target_angle_i      <= target;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_register(idx, val);
  endtask

  task automatic cfg_done();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [REG_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return REG_MAX;
      2:       return REG_W'($urandom_range(0, 1 << FRAC_BITS));
      3:       return REG_W'($urandom_range(0, 16 << FRAC_BITS));
      4:       return REG_W'($urandom);
      default: return REG_W'(1 << FRAC_BITS);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_deadband();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return REG_MAX;
      2:       return REG_W'($urandom);
      default: return REG_W'($urandom_range(1, 4 << FRAC_BITS));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return REG_MAX;
      2:       return REG_W'($urandom);
      default: return REG_W'($urandom_range(1, 64 << FRAC_BITS));
    endcase
  endfunction

  task automatic configure_phase(input int phase);
    logic [REG_W-1:0] c, k, e, j, db, lim;
    if (phase == 0) begin
      c = REG_MAX; k = REG_MAX; e = REG_MAX; j = REG_MAX; db = REG_MAX; lim = REG_MAX;
    end else if (phase == 1) begin
      c = '0; k = '0; e = '0; j = '0; db = '0; lim = '0;
    end else begin
      c = pick_gain(); k = pick_gain(); e = pick_gain(); j = pick_gain();
      db = pick_deadband(); lim = pick_limit();
    end
    cfg_write(CFG_SLOPE, c);
    cfg_write(CFG_REACH, k);
    cfg_write(CFG_SWITCH, e);
    cfg_write(CFG_INERTIA, j);
    cfg_write(CFG_DEADBAND, db);
    cfg_write(CFG_LIMIT, lim);
    cfg_write(($urandom_range(0, 1) != 0) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI,
              REG_W'($urandom));
    cfg_done();
    // keep the position error in the neighborhood of the deadband
    noise_span = (db != 0 && db < (31'h1 << 29)) ? 2 * db : 32'h4_0000;
    step_span  = $urandom_range(32'h100, 32'h8_0000);
  endtask

  task automatic make_item(output logic signed [DATA_W-1:0] angle,
                           output logic signed [DATA_W-1:0] vel,
                           output logic signed [DATA_W-1:0] target);
    int unsigned mode;
    longint      noise;
    mode  = $urandom_range(0, 19);
    noise = longint'($urandom_range(0, 2 * noise_span)) - longint'(noise_span);
    if (mode < 12) begin
      // smooth trajectory with small tracking error
      track_target = sb.clamp32(longint'(track_target)
                                + longint'($urandom_range(0, 2 * step_span))
                                - longint'(step_span));
      target = track_target;
      angle  = sb.clamp32(longint'(target) + noise);
      vel    = sb.clamp32(longint'($urandom_range(0, 32'h10_0000)) - 64'h8_0000);
    end else if (mode < 17) begin
      angle  = $urandom;
      vel    = $urandom;
      target = $urandom;
      track_target = target;
    end else begin
      // target jump with extreme velocity
      target = $urandom;
      angle  = sb.clamp32(longint'(target) + noise);
      vel    = ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
      track_target = target;
    end
  endtask

  initial begin
    logic signed [DATA_W-1:0] a, v, t;
    sb                  = new();
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_wdata_i         = '0;
    in_valid_i          = 1'b0;
    measured_angle_i    = '0;
    measured_velocity_i = '0;
    target_angle_i      = '0;
    out_ready_i         = 1'b0;
    idle_on             = 1'b1;
    hold_request        = 1'b0;
    stall_cycles        = 0;
    track_target        = '0;
    noise_span          = 32'h4_0000;
    step_span           = 32'h1_0000;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, saturating errors and target steps
    send_sample('0, '0, '0);
    send_sample(WORD_MAX, '0, WORD_MIN);
    send_sample(WORD_MIN, WORD_MAX, WORD_MAX);
    send_sample(WORD_MIN, WORD_MIN, WORD_MIN);
    send_sample(WORD_MAX, WORD_MAX, WORD_MAX);
    send_sample('0, WORD_MIN, WORD_MAX);
    send_sample('0, '0, WORD_MIN);
    stop_sending();
    wait_drained();

    // deadband edges and drive clamping
    cfg_write(CFG_SLOPE, 31'h3_0000);
    cfg_write(CFG_REACH, 31'h2_0000);
    cfg_write(CFG_SWITCH, 31'h8000);
    cfg_write(CFG_INERTIA, 31'h1_8000);
    cfg_write(CFG_DEADBAND, 31'h1_0000);
    cfg_write(CFG_LIMIT, 31'h3_0000);
    cfg_done();
    send_sample(32'sh10_8000, 32'sh1000, 32'sh10_0000);
    send_sample(32'sh1F_0001, -32'sh2000, 32'sh20_0000);
    send_sample(32'sh31_0000, '0, 32'sh30_0000);
    send_sample(32'sh2F_0000, '0, 32'sh30_0000);
    send_sample(32'sh700_0000, '0, '0);
    send_sample(-32'sh700_0000, '0, '0);
    send_sample('0, WORD_MAX, '0);
    send_sample('0, WORD_MIN, '0);
    stop_sending();
    wait_drained();

    // zero limit, writes to unmapped indexes are dropped
    cfg_write(CFG_LIMIT, '0);
    cfg_write(CFG_UNMAPPED_LO, REG_MAX);
    cfg_write(CFG_UNMAPPED_HI, REG_W'($urandom));
    cfg_done();
    send_sample(32'sh50_0000, 32'sh1234, '0);
    send_sample('0, '0, '0);
    stop_sending();
    wait_drained();

    // largest deadband still lets the most negative error through
    cfg_write(CFG_SLOPE, REG_MAX);
    cfg_write(CFG_REACH, REG_MAX);
    cfg_write(CFG_SWITCH, REG_MAX);
    cfg_write(CFG_INERTIA, REG_MAX);
    cfg_write(CFG_DEADBAND, REG_MAX);
    cfg_write(CFG_LIMIT, REG_MAX);
    cfg_done();
    send_sample(WORD_MIN, '0, '0);
    send_sample(WORD_MAX, WORD_MAX, WORD_MIN);
    send_sample(32'sh1000, -32'sh1000, '0);
    send_sample(WORD_MIN, WORD_MIN, WORD_MAX);
    stop_sending();
    wait_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      configure_phase(phase);
      idle_on = (phase < NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == 50) hold_request = 1'b1;
        make_item(a, v, t);
        send_sample(a, v, t);
      end
      stop_sending();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
